/* sv/tlvr_pkg.sv */
// Shared constants, result record and CRC-32 helpers for the TLV frame receiver.
// No dependencies; imported by tlvr_parser, tlv_frame_receiver_crc32, the checker and the testbench.
package tlvr_pkg;

    // Frame limits.
    localparam int unsigned RAW_FRAME_BYTES  = 256;
    localparam int unsigned PAYLOAD_CAPACITY = 128;

    localparam int unsigned RAW_W  = $clog2(RAW_FRAME_BYTES + 1);
    localparam int unsigned PCNT_W = $clog2(PAYLOAD_CAPACITY + 1);

    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;

    // Result kinds.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PAYLOAD = 2'd0;
    localparam kind_t KIND_END     = 2'd1;
    localparam kind_t KIND_ABORT   = 2'd2;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic [15:0] sequence_res;
        logic        crc_ok;
    } result_t;

    // Image of each single input bit after 32 shifts of the CRC register.
    // Evaluated only at elaboration.
    function automatic logic [1023:0] crc_columns();
        logic [1023:0] cols;
        logic [31:0]   v;
        cols = '0;
        for (int i = 0; i < 32; i++) begin
            v = 32'd1 << i;
            for (int j = 0; j < 32; j++) begin
                if (v[31]) begin
                    v = (v << 1) ^ CRC_POLY;
                end else begin
                    v = v << 1;
                end
            end
            cols[i*32 +: 32] = v;
        end
        return cols;
    endfunction

    localparam logic [1023:0] CRC_COLS = crc_columns();

    // One 32-bit word through the CRC: a single XOR matrix.
    function automatic logic [31:0] crc_word(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] x;
        logic [31:0] r;
        x = acc ^ w;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            r = r ^ ({32{x[i]}} & CRC_COLS[i*32 +: 32]);
        end
        return r;
    endfunction

endpackage

/* sv/tlv_frame_receiver_crc32.sv */
// TLV frame receiver: one byte per transaction, at most one result per byte.
// Results are registered: each one passes through the output stage to the m_ side.
// Throughput: one byte per cycle while the skid register is empty.
// A two-entry output stage (result register plus skid register) lets the next byte in
// while a result waits. Reset (aresetn low, synchronous) empties the output stage,
// returns the parser to waiting for a type byte and sets drop_idle_zero to 1.
// Depends on tlvr_pkg and tlvr_parser.
module tlv_frame_receiver_crc32 (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_drop_idle_zero,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_frame_length,
    output logic [15:0] m_sequence_res,
    output logic        m_crc_ok
);
    import tlvr_pkg::*;

    logic    drop_reg;
    logic    accept;
    logic    res_valid;
    result_t res;

    // Output stage: out_reg drives the m_ ports, skid_reg catches a result that
    // arrives while out_reg is still stalled.
    result_t out_reg,  out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    out_free;

    // Always ready; the user must write the register only while idle (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            drop_reg <= cfg_drop_idle_zero;
        end
    end

    // Input is taken whenever the skid register is empty, so a byte that makes
    // a result always has somewhere to put it.
    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    tlvr_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_valid     (accept),
        .rx_byte        (s_rx_byte),
        .drop_idle_zero (drop_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                // Skid full means no byte was accepted, so no new result.
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end else if (res_valid) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_frame_type   = out_reg.frame_type;
    assign m_frame_length = out_reg.frame_length;
    assign m_sequence_res = out_reg.sequence_res;
    assign m_crc_ok       = out_reg.crc_ok;

endmodule

/* sv/tlvr_parser.sv */
// Frame parser of the TLV receiver: phase sequencer, counters and CRC-32 accumulator.
// Depends on tlvr_pkg.
module tlvr_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [7:0]        rx_byte,
    input  logic              drop_idle_zero,
    output logic              res_valid,
    output tlvr_pkg::result_t res
);
    import tlvr_pkg::*;

    typedef enum logic [6:0] {
        PH_TYPE    = 7'b0000001,
        PH_LEN_LO  = 7'b0000010,
        PH_LEN_HI  = 7'b0000100,
        PH_SEQ_LO  = 7'b0001000,
        PH_SEQ_HI  = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_CRC     = 7'b1000000
    } phase_t;

    phase_t              phase_reg,    phase_next;
    logic [7:0]          type_reg,     type_next;
    logic [15:0]         length_reg,   length_next;
    logic [15:0]         seq_reg,      seq_next;
    logic [PCNT_W-1:0]   pcnt_reg,     pcnt_next;
    logic [RAW_W-1:0]    raw_reg,      raw_next;
    logic [31:0]         acc_reg,      acc_next;
    logic [23:0]         gather_reg,   gather_next;
    logic [1:0]          pos_reg,      pos_next;
    logic [23:0]         rcv_reg,      rcv_next;
    logic [1:0]          ccnt_reg,     ccnt_next;

    logic                waiting;
    logic [31:0]         crc_in;
    logic [31:0]         crc_out;
    logic [31:0]         feed_acc;
    logic [23:0]         feed_gather;
    logic [1:0]          feed_pos;
    logic [31:0]         fin;
    logic                ok;

    // One shared CRC matrix: fed the completed word during the frame, and the
    // zero-padded partial word when the final CRC byte arrives.
    assign crc_in  = (phase_reg == PH_CRC) ? {8'h00, gather_reg} : {rx_byte, gather_reg};
    assign crc_out = crc_word(acc_reg, crc_in);
    assign fin     = (pos_reg != 2'd0) ? crc_out : acc_reg;
    assign ok      = (fin == {rx_byte, rcv_reg});
    assign waiting = (phase_reg == PH_TYPE);

    // Effect of feeding the current byte into the word gatherer.
    always_comb begin
        feed_acc    = acc_reg;
        feed_gather = gather_reg;
        feed_pos    = pos_reg + 2'd1;
        case (pos_reg)
            2'd0: feed_gather[7:0]   = rx_byte;
            2'd1: feed_gather[15:8]  = rx_byte;
            2'd2: feed_gather[23:16] = rx_byte;
            default: begin
                feed_acc    = crc_out;
                feed_gather = '0;
                feed_pos    = 2'd0;
            end
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        seq_next    = seq_reg;
        pcnt_next   = pcnt_reg;
        raw_next    = raw_reg;
        acc_next    = acc_reg;
        gather_next = gather_reg;
        pos_next    = pos_reg;
        rcv_next    = rcv_reg;
        ccnt_next   = ccnt_reg;
        res_valid   = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = 8'h00;
        res.frame_type   = type_reg;
        res.frame_length = length_reg;
        res.sequence_res = seq_reg;
        res.crc_ok       = 1'b0;

        if (byte_valid && !(waiting && (rx_byte == 8'h00) && drop_idle_zero)) begin
            if (raw_reg >= RAW_W'(RAW_FRAME_BYTES)) begin
                // Raw overflow: abort and start over, the type byte is kept.
                res_valid   = 1'b1;
                res.kind    = KIND_ABORT;
                length_next = '0;
                seq_next    = '0;
                phase_next  = PH_TYPE;
                pcnt_next   = '0;
                raw_next    = '0;
                acc_next    = '1;
                gather_next = '0;
                pos_next    = '0;
                rcv_next    = '0;
                ccnt_next   = '0;
            end else begin
                raw_next = raw_reg + 1'b1;
                case (phase_reg)
                    PH_TYPE: begin
                        acc_next    = feed_acc;
                        gather_next = feed_gather;
                        pos_next    = feed_pos;
                        type_next   = rx_byte;
                        length_next = '0;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        acc_next    = feed_acc;
                        gather_next = feed_gather;
                        pos_next    = feed_pos;
                        length_next = {8'h00, rx_byte};
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        acc_next    = feed_acc;
                        gather_next = feed_gather;
                        pos_next    = feed_pos;
                        length_next = {rx_byte, length_reg[7:0]};
                        phase_next  = PH_SEQ_LO;
                    end
                    PH_SEQ_LO: begin
                        acc_next    = feed_acc;
                        gather_next = feed_gather;
                        pos_next    = feed_pos;
                        seq_next    = {8'h00, rx_byte};
                        phase_next  = PH_SEQ_HI;
                    end
                    PH_SEQ_HI: begin
                        acc_next    = feed_acc;
                        gather_next = feed_gather;
                        pos_next    = feed_pos;
                        seq_next    = {rx_byte, seq_reg[7:0]};
                        pcnt_next   = '0;
                        rcv_next    = '0;
                        ccnt_next   = '0;
                        phase_next  = (length_reg == 16'd0) ? PH_CRC : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        acc_next    = feed_acc;
                        gather_next = feed_gather;
                        pos_next    = feed_pos;
                        if (pcnt_reg < PCNT_W'(PAYLOAD_CAPACITY)) begin
                            pcnt_next        = pcnt_reg + 1'b1;
                            res_valid        = 1'b1;
                            res.kind         = KIND_PAYLOAD;
                            res.payload_byte = rx_byte;
                        end
                        if (16'(pcnt_next) >= length_reg) begin
                            rcv_next   = '0;
                            ccnt_next  = '0;
                            phase_next = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        if (ccnt_reg == 2'd3) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_END;
                            res.crc_ok = ok;
                            if (!ok) begin
                                length_next = '0;
                                seq_next    = '0;
                            end
                            phase_next  = PH_TYPE;
                            pcnt_next   = '0;
                            raw_next    = '0;
                            acc_next    = '1;
                            gather_next = '0;
                            pos_next    = '0;
                            rcv_next    = '0;
                            ccnt_next   = '0;
                        end else begin
                            case (ccnt_reg)
                                2'd0:    rcv_next[7:0]   = rx_byte;
                                2'd1:    rcv_next[15:8]  = rx_byte;
                                default: rcv_next[23:16] = rx_byte;
                            endcase
                            ccnt_next = ccnt_reg + 2'd1;
                        end
                    end
                    default: begin
                        phase_next = PH_TYPE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TYPE;
            type_reg   <= '0;
            length_reg <= '0;
            seq_reg    <= '0;
            pcnt_reg   <= '0;
            raw_reg    <= '0;
            acc_reg    <= '1;
            gather_reg <= '0;
            pos_reg    <= '0;
            rcv_reg    <= '0;
            ccnt_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            seq_reg    <= seq_next;
            pcnt_reg   <= pcnt_next;
            raw_reg    <= raw_next;
            acc_reg    <= acc_next;
            gather_reg <= gather_next;
            pos_reg    <= pos_next;
            rcv_reg    <= rcv_next;
            ccnt_reg   <= ccnt_next;
        end
    end

endmodule

/* dv/tlvr_frame_checker.sv */
// Checker for the TLV frame receiver: tracks the parser from the byte and
// configuration transactions and compares every result transaction it sees.
// Depends on tlvr_pkg for the result record, kind codes and frame limits.
module tlvr_frame_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_drop_idle_zero,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_kind,
    input  logic [7:0]         m_payload_byte,
    input  logic [7:0]         m_frame_type,
    input  logic [15:0]        m_frame_length,
    input  logic [15:0]        m_sequence_res,
    input  logic               m_crc_ok,
    output int unsigned        fail_count,
    output int unsigned        results_due,
    output logic               parser_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlvr_pkg::*;

    typedef enum logic [6:0] {
        WAIT_TYPE = 7'b0000001,
        LEN_LO    = 7'b0000010,
        LEN_HI    = 7'b0000100,
        SEQ_LO    = 7'b0001000,
        SEQ_HI    = 7'b0010000,
        PAYLOAD   = 7'b0100000,
        CRC_TAIL  = 7'b1000000
    } rx_phase_t;

    logic             drop_zero;
    rx_phase_t        ph;
    logic [7:0]       typ;
    logic [15:0]      len;
    logic [15:0]      seqn;
    logic [15:0]      pcount;
    logic [RAW_W-1:0] raw;
    logic [31:0]      crc_acc;
    logic [31:0]      crc_rx;
    logic [23:0]      gather;
    logic [1:0]       gpos;
    logic [2:0]       crc_cnt;
    result_t          pending_results[$];

    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] r;
        r = acc ^ w;
        for (int i = 0; i < 32; i++) begin
            r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    task automatic restart_frame();
        ph      = WAIT_TYPE;
        pcount  = '0;
        raw     = '0;
        crc_acc = '1;
        gather  = '0;
        gpos    = '0;
        crc_rx  = '0;
        crc_cnt = '0;
    endtask

    // Frame bytes are packed little-endian into words; every fourth byte
    // pushes a whole word through the CRC.
    task automatic absorb(input logic [7:0] b);
        if (gpos == 2'd3) begin
            crc_acc = crc32_step(crc_acc, {b, gather});
            gather  = '0;
            gpos    = '0;
        end else begin
            gather = gather | (24'(b) << (8 * gpos));
            gpos   = gpos + 2'd1;
        end
    endtask

    task automatic post_result(input kind_t k, input logic [7:0] pb, input logic ok);
        result_t r;
        r.kind         = k;
        r.payload_byte = pb;
        r.frame_type   = typ;
        r.frame_length = len;
        r.sequence_res = seqn;
        r.crc_ok       = ok;
        pending_results.push_back(r);
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        logic [31:0] fin;
        if (ph == WAIT_TYPE && b == 8'h00 && drop_zero) begin
            return;
        end
        if (raw >= RAW_FRAME_BYTES) begin
            post_result(KIND_ABORT, 8'h00, 1'b0);
            len  = '0;
            seqn = '0;
            restart_frame();
            return;
        end
        raw = raw + 1'b1;
        case (ph)
            WAIT_TYPE: begin
                absorb(b);
                typ = b;
                len = '0;
                ph  = LEN_LO;
            end
            LEN_LO: begin
                absorb(b);
                len = {8'h00, b};
                ph  = LEN_HI;
            end
            LEN_HI: begin
                absorb(b);
                len[15:8] = b;
                ph        = SEQ_LO;
            end
            SEQ_LO: begin
                absorb(b);
                seqn = {8'h00, b};
                ph   = SEQ_HI;
            end
            SEQ_HI: begin
                absorb(b);
                seqn[15:8] = b;
                pcount     = '0;
                crc_rx     = '0;
                crc_cnt    = '0;
                ph         = (len == 16'd0) ? CRC_TAIL : PAYLOAD;
            end
            PAYLOAD: begin
                absorb(b);
                // Past the capacity nothing is stored, so the count stalls and
                // the frame can only end through the raw overflow.
                if (pcount < PAYLOAD_CAPACITY) begin
                    pcount = pcount + 16'd1;
                    post_result(KIND_PAYLOAD, b, 1'b0);
                end
                if (pcount >= len) begin
                    crc_rx  = '0;
                    crc_cnt = '0;
                    ph      = CRC_TAIL;
                end
            end
            default: begin
                crc_rx  = crc_rx | (32'(b) << (8 * crc_cnt[1:0]));
                crc_cnt = crc_cnt + 3'd1;
                if (crc_cnt >= 3'd4) begin
                    fin = crc_acc;
                    if (gpos != 2'd0) begin
                        fin = crc32_step(fin, {8'h00, gather});
                    end
                    post_result(KIND_END, 8'h00, fin == crc_rx);
                    if (fin != crc_rx) begin
                        len  = '0;
                        seqn = '0;
                    end
                    restart_frame();
                end
            end
        endcase
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        result_t w;
        if (pending_results.size() == 0) begin
            $error("result of kind %0d arrived with nothing outstanding", m_kind);
            fail_count++;
            return;
        end
        w = pending_results.pop_front();
        check_field("kind", w.kind, m_kind);
        check_field("payload_byte", w.payload_byte, m_payload_byte);
        check_field("frame_type", w.frame_type, m_frame_type);
        check_field("frame_length", w.frame_length, m_frame_length);
        check_field("sequence_res", w.sequence_res, m_sequence_res);
        check_field("crc_ok", w.crc_ok, m_crc_ok);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count = 0;
            drop_zero  = 1'b1;
            typ        = '0;
            len        = '0;
            seqn       = '0;
            restart_frame();
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                drop_zero = cfg_drop_idle_zero;
            end
            if (s_valid && s_ready) begin
                predict_rx_byte(s_rx_byte);
            end
            if (m_valid && m_ready) begin
                check_result();
            end
        end
        results_due = pending_results.size();
        parser_idle = (ph == WAIT_TYPE);
    end

endmodule

/* dv/tb_tlv_frame_receiver_crc32.sv */
// Top of the TLV frame receiver testbench: clock, reset, byte and configuration
// stimulus, random back-pressure and the final verdict.
// Depends on tlvr_pkg, tlv_frame_receiver_crc32 and tlvr_frame_checker.
module tb_tlv_frame_receiver_crc32;
    timeunit 1ns;
    timeprecision 1ps;

    import tlvr_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // The random part is split into four phases, alternating the idle-zero
    // mode, so both settings see a large share of the traffic.
    localparam int unsigned PHASE_ITEMS = 480;
    // Generous ceiling: even with every byte meeting the longest gap and the
    // longest output stall the run stays far below this.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic        aclk               = 1'b0;
    logic        aresetn            = 1'b0;
    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte          = 8'h00;
    logic        cfg_valid          = 1'b0;
    logic        cfg_ready;
    logic        cfg_drop_idle_zero = 1'b1;
    logic        m_valid;
    logic        m_ready            = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_frame_type;
    logic [15:0] m_frame_length;
    logic [15:0] m_sequence_res;
    logic        m_crc_ok;

    int unsigned fail_count;
    int unsigned results_due;
    logic        parser_idle;

    int unsigned cycles          = 0;
    int unsigned items_sent      = 0;
    int unsigned frames_good     = 0;
    int unsigned frames_bad      = 0;
    int unsigned broken_seqs     = 0;
    int unsigned oversize_frames = 0;
    int unsigned phase_end       = 0;
    int unsigned hold_left       = 0;
    int unsigned sink_roll       = 0;
    logic        drop_mode       = 1'b1;
    bit          source_steady   = 1'b0;
    bit          sink_steady     = 1'b0;
    byte_q_t     body;

    tlv_frame_receiver_crc32 u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_drop_idle_zero (cfg_drop_idle_zero),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_payload_byte     (m_payload_byte),
        .m_frame_type       (m_frame_type),
        .m_frame_length     (m_frame_length),
        .m_sequence_res     (m_sequence_res),
        .m_crc_ok           (m_crc_ok)
    );

    tlvr_frame_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_drop_idle_zero (cfg_drop_idle_zero),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_payload_byte     (m_payload_byte),
        .m_frame_type       (m_frame_type),
        .m_frame_length     (m_frame_length),
        .m_sequence_res     (m_sequence_res),
        .m_crc_ok           (m_crc_ok),
        .fail_count         (fail_count),
        .results_due        (results_due),
        .parser_idle        (parser_idle)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here rather than never.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_tlv_frame_receiver_crc32: done, errors");
            $finish;
        end
    end

    // Result side back-pressure. Stalls come from a short and a rarer long range;
    // while sink_steady is set the sink starts no new stall.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = 1'b1;
            if (!sink_steady) begin
                sink_roll = $urandom_range(0, 99);
                if (sink_roll < 3) begin
                    hold_left = $urandom_range(12, 40);
                end else if (sink_roll < 25) begin
                    hold_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // CRC as the block computes it: 32-bit words gathered little-endian from
    // the frame bytes, the last word zero padded, MSB-first shifting, seed of
    // all ones and no final inversion.
    function automatic logic [31:0] frame_crc(input byte_q_t bytes_q);
        logic [31:0] acc;
        logic [31:0] w;
        acc = '1;
        for (int i = 0; i < bytes_q.size(); i += 4) begin
            w = '0;
            for (int k = 0; k < 4; k++) begin
                if (i + k < bytes_q.size()) begin
                    w[8*k +: 8] = bytes_q[i+k];
                end
            end
            acc = acc ^ w;
            repeat (32) acc = acc[31] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
        end
        return acc;
    endfunction

    // Builds the full byte image of a frame; with bad_crc set a single bit
    // of the trailing CRC is flipped.
    function automatic byte_q_t build_frame(input logic [7:0] ftype, input logic [15:0] fseq,
                                            input byte_q_t fbody, input bit bad_crc);
        byte_q_t     bytes_q;
        logic [15:0] flen;
        logic [31:0] crc;
        flen    = 16'(fbody.size());
        bytes_q = {ftype, flen[7:0], flen[15:8], fseq[7:0], fseq[15:8]};
        foreach (fbody[i]) bytes_q.push_back(fbody[i]);
        crc = frame_crc(bytes_q);
        if (bad_crc) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        for (int k = 0; k < 4; k++) begin
            bytes_q.push_back(crc[8*k +: 8]);
        end
        return bytes_q;
    endfunction

    // One byte transaction. A random gap may come first, with valid low;
    // once raised, valid and the byte hold until the block takes them.
    task automatic push_byte(input logic [7:0] b, input bit counts = 1'b1);
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        gap  = 0;
        if (!source_steady) begin
            if (roll < 3) begin
                gap = $urandom_range(12, 40);
            end else if (roll < 30) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (counts) begin
            items_sent++;
        end
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] fseq,
                              input byte_q_t fbody, input bit bad_crc);
        byte_q_t frame;
        frame = build_frame(ftype, fseq, fbody, bad_crc);
        foreach (frame[i]) push_byte(frame[i]);
    endtask

    // Zero bytes bring the parser back to waiting for a type byte quickly: where
    // they land in the length field they make a zero length, so only the CRC bytes remain. The loop stops as
    // soon as the parser is waiting, so no zero here is ever dropped.
    task automatic flush_to_idle();
        while (!parser_idle) push_byte(8'h00);
    endtask

    // The register is only written with no result outstanding. A byte that makes
    // no result may still be in the block, so the write also waits that byte out.
    task automatic set_drop_idle_zero(input logic v);
        s_valid = 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid          = 1'b1;
        cfg_drop_idle_zero = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
        drop_mode = v;
    endtask

    // A header declaring more payload than the block can store. Those frames
    // never reach their CRC; random bytes follow until the raw byte limit
    // aborts the frame and the parser is waiting again.
    task automatic send_oversize(input logic [15:0] flen);
        logic [15:0] fseq;
        fseq = 16'($urandom);
        push_byte(8'($urandom_range(1, 255)));
        push_byte(flen[7:0]);
        push_byte(flen[15:8]);
        push_byte(fseq[7:0]);
        push_byte(fseq[15:8]);
        while (!parser_idle) push_byte(8'($urandom));
        oversize_frames++;
    endtask

    // One random sequence: mostly well-formed frames with random contents,
    // some with a corrupted CRC, some idle zeros, and a few truncated frames
    // or bursts of noise. Whatever happened, zero bytes then resynchronise.
    task automatic random_sequence();
        byte_q_t     fbody;
        byte_q_t     frame;
        int unsigned roll;
        int unsigned size_roll;
        int unsigned flen;
        int unsigned cut;
        if ($urandom_range(0, 9) == 0) source_steady = !source_steady;
        if ($urandom_range(0, 9) == 0) sink_steady = !sink_steady;

        // Mostly short payloads; the capacity itself now and then.
        size_roll = $urandom_range(0, 99);
        if (size_roll < 70) begin
            flen = $urandom_range(0, 8);
        end else if (size_roll < 95) begin
            flen = $urandom_range(9, 40);
        end else if (size_roll < 99) begin
            flen = $urandom_range(41, PAYLOAD_CAPACITY);
        end else begin
            flen = PAYLOAD_CAPACITY;
        end
        repeat (flen) fbody.push_back(8'($urandom));

        roll = $urandom_range(0, 99);
        if (roll < 6 && drop_mode) begin
            // Idle zeros are dropped by the block and so are not counted.
            repeat ($urandom_range(1, 3)) push_byte(8'h00, 1'b0);
        end else if (roll < 82) begin
            send_frame(8'($urandom), 16'($urandom), fbody, 1'b0);
            frames_good++;
        end else if (roll < 93) begin
            send_frame(8'($urandom), 16'($urandom), fbody, 1'b1);
            frames_bad++;
        end else begin
            if (roll[0]) begin
                frame = build_frame(8'($urandom), 16'($urandom), fbody, 1'b0);
                cut   = $urandom_range(1, frame.size() - 1);
                for (int i = 0; i < cut; i++) begin
                    push_byte(frame[i]);
                end
            end else begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
            end
            broken_seqs++;
        end
        flush_to_idle();
    endtask

    initial begin
        // Synchronous reset, released on a falling clock edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part. With the reset setting an idle zero is discarded,
        // then an empty frame with all-ones type and sequence goes straight
        // from the sequence number to its CRC.
        push_byte(8'h00, 1'b0);
        body.delete();
        send_frame(8'hFF, 16'hFFFF, body, 1'b0);
        frames_good++;

        // With idle-zero dropping off, a zero byte is a type byte like any
        // other. Extreme payload bytes and a corrupted CRC, which must clear
        // the reported length and sequence once the frame ends.
        set_drop_idle_zero(1'b0);
        body = {8'h00, 8'hFF};
        send_frame(8'h00, 16'h0000, body, 1'b1);
        frames_bad++;

        // Random part in four phases alternating the idle-zero mode. The first
        // and third phases open with an oversize frame: the largest declared
        // length, then one byte beyond the payload capacity.
        for (int p = 0; p < 4; p++) begin
            set_drop_idle_zero(p % 2 == 0);
            phase_end = items_sent + PHASE_ITEMS;
            if (p == 0) begin
                send_oversize(16'hFFFF);
            end else if (p == 2) begin
                send_oversize(16'(PAYLOAD_CAPACITY + 1));
            end
            while (items_sent < phase_end) random_sequence();
        end

        // Drain: wait for every outstanding result, then keep watching for
        // anything unexpected to show up.
        s_valid = 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("run covered %0d bytes: %0d good frames, %0d with a bad CRC, %0d oversize",
                 items_sent, frames_good, frames_bad, oversize_frames);
        $display("plus %0d truncated or noisy sequences, with idle zeros kept and dropped",
                 broken_seqs);
        if (fail_count == 0 && results_due == 0) begin
            $display("tb_tlv_frame_receiver_crc32: done, clean");
        end else begin
            $display("tb_tlv_frame_receiver_crc32: done, errors");
        end
        $finish;
    end

endmodule
